// ===== hdl/asms_pkg.sv =====
// Package: constants, types and helpers for the ADI min-max shift selector.
package asms_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_SHIFTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;

    localparam int PIDX_W = $clog2(MAX_POINTS);
    localparam int PCNT_W = PIDX_W + 1;
    localparam int SIDX_W = $clog2(MAX_SHIFTS);
    localparam int SCNT_W = SIDX_W + 1;
    localparam int DES_W  = 6;

    // ratio datapath widths
    localparam int MAG_W  = 31;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int LIM_W  = 64 - FRAC_BITS;
    localparam int SH2_N  = SUM_W - LIM_W;
    localparam int SH2_W  = $clog2(SH2_N + 1);

    localparam logic [DATA_W-1:0] SAT32  = '1;
    localparam logic [DATA_W-1:0] RP_ONE = DATA_W'(1) << FRAC_BITS;

    // register map
    localparam logic [2:0]       ADDR_DESIRED  = 3'd0;
    localparam logic [DES_W-1:0] DESIRED_RESET = DES_W'(8);

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } cplx_t;

    typedef enum logic [4:0] {
        C_IDLE, C_ERR, C_MM_RDI, C_MM_LDI, C_MM_LDK, C_MM_WAIT, C_RP_INIT,
        C_AP_RD, C_AP_LD, C_AS_RD, C_AS_LD, C_AS_WAIT, C_AS_WR,
        C_PK_RD, C_PK_RUN, C_EM_RD, C_EM_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        R_IDLE, R_SQ, R_NORM, R_SAT, R_DIV, R_DONE
    } rat_state_t;

    // conjugate of the imaginary part, saturating the most negative code
    function automatic logic signed [DATA_W-1:0] conj_im(logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v == {1'b1, {(DATA_W-1){1'b0}}})
            r = {1'b0, {(DATA_W-1){1'b1}}};
        else
            r = -v;
        return r;
    endfunction

endpackage

// ===== hdl/asms_point_if.sv =====
// Interface: input point channel.
interface asms_point_if
    import asms_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_real;
    logic signed [DATA_W-1:0] value_imag;
    logic                     last_point;

    modport source (output valid, value_real, value_imag, last_point, input ready);
    modport sink   (input valid, value_real, value_imag, last_point, output ready);
endinterface

// ===== hdl/asms_shift_if.sv =====
// Interface: output shift channel.
interface asms_shift_if
    import asms_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] shift_real;
    logic signed [DATA_W-1:0] shift_imag;
    logic                     shift_last;
    logic                     status;

    modport source (output valid, shift_real, shift_imag, shift_last, status, input ready);
    modport sink   (input valid, shift_real, shift_imag, shift_last, status, output ready);
endinterface

// ===== hdl/asms_ratio.sv =====
// Multi-cycle unit computing |p-x|^2 / |p+x|^2 in fixed point, saturated.
module asms_ratio
    import asms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cplx_t             p,
    input  cplx_t             x,
    output logic              done,
    output logic [DATA_W-1:0] q
);

    rat_state_t              state_reg, state_next;
    logic [MAG_W-1:0]        m_reg [4];
    logic [MAG_W-1:0]        m_next [4];
    logic [2:0]              sq_cnt_reg, sq_cnt_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [SUM_W-1:0]        num_reg, num_next;
    logic [SUM_W-1:0]        den_reg, den_next;
    logic [SUM_W-1:0]        rem_reg, rem_next;
    logic [DATA_W-1:0]       lo_reg, lo_next;
    logic [DATA_W-1:0]       q_reg, q_next;
    logic [4:0]              dcnt_reg, dcnt_next;

    logic signed [DATA_W:0]  dv [4];
    logic [DATA_W:0]         mv [4];
    logic                    any32, any31;
    logic [SH2_W-1:0]        s2;
    logic [DATA_W-1:0]       hi;
    logic [SUM_W:0]          rem2;

    // operand magnitudes: p-x and p+x per component
    always_comb
    begin
        dv[0] = {p.re[DATA_W-1], p.re} - {x.re[DATA_W-1], x.re};
        dv[1] = {p.im[DATA_W-1], p.im} - {x.im[DATA_W-1], x.im};
        dv[2] = {p.re[DATA_W-1], p.re} + {x.re[DATA_W-1], x.re};
        dv[3] = {p.im[DATA_W-1], p.im} + {x.im[DATA_W-1], x.im};
        for (int j = 0; j < 4; j++)
            mv[j] = dv[j][DATA_W] ? DATA_W'(0) - dv[j] : dv[j];
        any32 = mv[0][32] | mv[1][32] | mv[2][32] | mv[3][32];
        any31 = mv[0][31] | mv[1][31] | mv[2][31] | mv[3][31];
    end

    // common right shift so that num stays below 2^(64-FRAC_BITS)
    always_comb
    begin
        s2 = '0;
        for (int j = 0; j < SH2_N; j++)
            if (num_reg[LIM_W + j])
                s2 = SH2_W'(j + 1);
    end

    assign hi   = num_reg[63-FRAC_BITS -: DATA_W];
    assign rem2 = {rem_reg, lo_reg[DATA_W-1]};

    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        sq_cnt_next = sq_cnt_reg;
        sq_next     = sq_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        lo_next     = lo_reg;
        q_next      = q_reg;
        dcnt_next   = dcnt_reg;
        done        = 1'b0;
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    for (int j = 0; j < 4; j++)
                        m_next[j] = any32 ? mv[j][MAG_W+1:2] :
                                    any31 ? mv[j][MAG_W:1] : mv[j][MAG_W-1:0];
                    sq_cnt_next = '0;
                    num_next    = '0;
                    den_next    = '0;
                    state_next  = R_SQ;
                end
            end
            R_SQ:
            begin
                // square one lane, accumulate the previous square
                if (sq_cnt_reg < 3'd4)
                    sq_next = m_reg[sq_cnt_reg[1:0]] * m_reg[sq_cnt_reg[1:0]];
                if (sq_cnt_reg == 3'd1 || sq_cnt_reg == 3'd2)
                    num_next = num_reg + SUM_W'(sq_reg);
                if (sq_cnt_reg == 3'd3 || sq_cnt_reg == 3'd4)
                    den_next = den_reg + SUM_W'(sq_reg);
                sq_cnt_next = sq_cnt_reg + 3'd1;
                if (sq_cnt_reg == 3'd4)
                    state_next = R_NORM;
            end
            R_NORM:
            begin
                num_next   = num_reg >> s2;
                den_next   = den_reg >> s2;
                state_next = R_SAT;
            end
            R_SAT:
            begin
                // quotient overflows 32 bits when the high half reaches den
                if (SUM_W'(hi) >= den_reg)
                begin
                    q_next     = SAT32;
                    state_next = R_DONE;
                end
                else
                begin
                    rem_next   = SUM_W'(hi);
                    lo_next    = {num_reg[DATA_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
                    q_next     = '0;
                    dcnt_next  = '0;
                    state_next = R_DIV;
                end
            end
            R_DIV:
            begin
                // restoring division, one quotient bit per cycle
                lo_next = {lo_reg[DATA_W-2:0], 1'b0};
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_next = SUM_W'(rem2 - {1'b0, den_reg});
                    q_next   = {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[SUM_W-1:0];
                    q_next   = {q_reg[DATA_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd31)
                    state_next = R_DONE;
            end
            R_DONE:
            begin
                done       = 1'b1;
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    assign q = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= R_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        sq_cnt_reg <= sq_cnt_next;
        sq_reg     <= sq_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        q_reg      <= q_next;
        dcnt_reg   <= dcnt_next;
    end

endmodule

// ===== hdl/adi_shift_minmax_select.sv =====
// Top level: loads points, selects ADI shifts by the min-max heuristic, emits them.
// Loading: one point per cycle, no stall.
// Selection: N^2 ratio evaluations plus N per added shift, each in the shared
// ratio unit (5 square, scale, saturate, 32 divide steps); picks scan N products.
// Emission: each shift is read from the shift memory into the output register.
// Reset clears counts and the control state; desired_shifts resets to 8.
module adi_shift_minmax_select
    import asms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    asms_point_if.sink  points,
    asms_shift_if.source shifts,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ctl_state_t          state_reg, state_next;
    logic [DES_W-1:0]    desired_reg;
    logic [PCNT_W-1:0]   pcnt_reg, pcnt_next;
    logic [SCNT_W-1:0]   scnt_reg, scnt_next;
    logic [PCNT_W-1:0]   i_reg, i_next;
    logic [PCNT_W-1:0]   k_reg, k_next;
    logic [SCNT_W-1:0]   e_reg, e_next;
    logic [DATA_W-1:0]   worst_reg, worst_next;
    logic [DATA_W-1:0]   best_reg, best_next;
    logic [PIDX_W-1:0]   bidx_reg, bidx_next;
    cplx_t               p_reg, p_next;
    cplx_t               sel_reg, sel_next;
    logic                conj_reg, conj_next;
    logic [DATA_W-1:0]   rph_reg, rph_next;
    logic [2*DATA_W-1:0] prod_reg, prod_next;

    // output register
    logic                ov_reg, ov_next;
    cplx_t               od_reg, od_next;
    logic                olast_reg, olast_next;
    logic                ostat_reg, ostat_next;
    logic                out_free;

    // memories
    cplx_t               pt_mem [MAX_POINTS];
    cplx_t               sh_mem [MAX_SHIFTS];
    logic [DATA_W-1:0]   rp_mem [MAX_POINTS];
    cplx_t               pt_q_reg;
    cplx_t               sh_q_reg;
    logic [DATA_W-1:0]   rp_q_reg;
    logic [PIDX_W-1:0]   rd_addr;
    logic [SIDX_W-1:0]   sh_raddr;
    logic                pt_we;
    logic                rp_we;
    logic [DATA_W-1:0]   rp_wdata;
    logic                sh_we;
    cplx_t               sh_wdata;

    // ratio unit
    logic                rat_start;
    cplx_t               rat_p;
    logic                rat_done;
    logic [DATA_W-1:0]   rat_q;

    logic                in_xfer;
    logic [PCNT_W-1:0]   pcnt_inc;
    logic [DATA_W-1:0]   w;
    logic [SCNT_W:0]     s_need;
    logic [PCNT_W-1:0]   k_inc;

    asms_ratio u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rat_start),
        .p     (rat_p),
        .x     (pt_q_reg),
        .done  (rat_done),
        .q     (rat_q)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_DESIRED[2]) ? 32'(desired_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            desired_reg <= DESIRED_RESET;
        else if (psel && penable && pwrite && paddr[2] == ADDR_DESIRED[2])
            desired_reg <= pwdata[DES_W-1:0];
    end

    assign points.ready = (state_reg == C_IDLE);
    assign in_xfer      = points.valid && points.ready;
    assign out_free     = !ov_reg || shifts.ready;
    assign pcnt_inc     = (pcnt_reg < PCNT_W'(MAX_POINTS)) ? pcnt_reg + 1'b1 : pcnt_reg;
    assign k_inc        = k_reg + 1'b1;
    assign pt_we        = in_xfer && (pcnt_reg < PCNT_W'(MAX_POINTS));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pcnt_next  = pcnt_reg;
        scnt_next  = scnt_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        worst_next = worst_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        p_next     = p_reg;
        sel_next   = sel_reg;
        conj_next  = conj_reg;
        rph_next   = rph_reg;
        prod_next  = prod_reg;
        ov_next    = ov_reg && !shifts.ready;
        od_next    = od_reg;
        olast_next = olast_reg;
        ostat_next = ostat_reg;
        rd_addr    = k_reg[PIDX_W-1:0];
        sh_raddr   = e_reg[SIDX_W-1:0];
        rp_we      = 1'b0;
        rp_wdata   = RP_ONE;
        sh_we      = 1'b0;
        sh_wdata   = sel_reg;
        rat_start  = 1'b0;
        rat_p      = sel_reg;
        w          = (k_reg == '0 || rat_q > worst_reg) ? rat_q : worst_reg;
        s_need     = '0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_xfer)
                begin
                    pcnt_next = pcnt_inc;
                    if (points.last_point)
                    begin
                        i_next = '0;
                        if (pcnt_inc < PCNT_W'(desired_reg))
                            state_next = C_ERR;
                        else
                            state_next = C_MM_RDI;
                    end
                end
            end
            C_ERR:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = '0;
                    olast_next = 1'b1;
                    ostat_next = 1'b1;
                    pcnt_next  = '0;
                    scnt_next  = '0;
                    state_next = C_IDLE;
                end
            end
            // first shift: least worst-case ratio
            C_MM_RDI:
            begin
                rd_addr    = i_reg[PIDX_W-1:0];
                state_next = C_MM_LDI;
            end
            C_MM_LDI:
            begin
                p_next     = pt_q_reg;
                k_next     = '0;
                rd_addr    = '0;
                state_next = C_MM_LDK;
            end
            C_MM_LDK:
            begin
                rat_start  = 1'b1;
                rat_p      = p_reg;
                state_next = C_MM_WAIT;
            end
            C_MM_WAIT:
            begin
                if (rat_done)
                begin
                    worst_next = w;
                    if (k_inc < pcnt_reg)
                    begin
                        k_next     = k_inc;
                        rd_addr    = k_inc[PIDX_W-1:0];
                        state_next = C_MM_LDK;
                    end
                    else
                    begin
                        if (i_reg == '0 || w < best_reg)
                        begin
                            best_next = w;
                            bidx_next = i_reg[PIDX_W-1:0];
                        end
                        k_next = '0;
                        if (i_reg + 1'b1 < pcnt_reg)
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = C_MM_RDI;
                        end
                        else
                            state_next = C_RP_INIT;
                    end
                end
            end
            // running products start at one
            C_RP_INIT:
            begin
                rp_we    = 1'b1;
                rp_wdata = RP_ONE;
                if (k_inc < pcnt_reg)
                    k_next = k_inc;
                else
                begin
                    scnt_next  = '0;
                    state_next = C_AP_RD;
                end
            end
            // add the chosen point and its conjugate when complex
            C_AP_RD:
            begin
                rd_addr    = bidx_reg;
                state_next = C_AP_LD;
            end
            C_AP_LD:
            begin
                s_need = {1'b0, scnt_reg} + ((pt_q_reg.im != '0) ? 2'd2 : 2'd1);
                if (s_need > (SCNT_W+1)'(MAX_SHIFTS))
                begin
                    e_next     = '0;
                    state_next = C_EM_RD;
                end
                else
                begin
                    sh_we      = 1'b1;
                    sh_wdata   = pt_q_reg;
                    scnt_next  = scnt_reg + 1'b1;
                    sel_next   = pt_q_reg;
                    conj_next  = (pt_q_reg.im != '0);
                    k_next     = '0;
                    state_next = C_AS_RD;
                end
            end
            // fold the new shift's ratio into every running product
            C_AS_RD:
            begin
                state_next = C_AS_LD;
            end
            C_AS_LD:
            begin
                rat_start  = 1'b1;
                rph_next   = rp_q_reg;
                state_next = C_AS_WAIT;
            end
            C_AS_WAIT:
            begin
                if (rat_done)
                begin
                    prod_next  = rph_reg * rat_q;
                    state_next = C_AS_WR;
                end
            end
            C_AS_WR:
            begin
                rp_we    = 1'b1;
                rp_wdata = (prod_reg[2*DATA_W-1:DATA_W+FRAC_BITS] != '0) ? SAT32 :
                           prod_reg[DATA_W+FRAC_BITS-1:FRAC_BITS];
                if (k_inc < pcnt_reg)
                begin
                    k_next     = k_inc;
                    state_next = C_AS_RD;
                end
                else if (conj_reg)
                begin
                    conj_next   = 1'b0;
                    sel_next.im = conj_im(sel_reg.im);
                    sh_we       = 1'b1;
                    sh_wdata    = '{re: sel_reg.re, im: conj_im(sel_reg.im)};
                    scnt_next   = scnt_reg + 1'b1;
                    k_next      = '0;
                    state_next  = C_AS_RD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = C_PK_RD;
                end
            end
            // greatest running product, ties to the first
            C_PK_RD:
            begin
                rd_addr    = '0;
                state_next = C_PK_RUN;
            end
            C_PK_RUN:
            begin
                rd_addr = k_inc[PIDX_W-1:0];
                if (k_reg == '0 || rp_q_reg > best_reg)
                begin
                    best_next = rp_q_reg;
                    bidx_next = k_reg[PIDX_W-1:0];
                end
                if (k_inc < pcnt_reg)
                    k_next = k_inc;
                else if (scnt_reg < SCNT_W'(desired_reg))
                    state_next = C_AP_RD;
                else
                begin
                    e_next     = '0;
                    state_next = C_EM_RD;
                end
            end
            // emit the shift list
            C_EM_RD:
            begin
                state_next = C_EM_OUT;
            end
            C_EM_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = sh_q_reg;
                    ostat_next = 1'b0;
                    olast_next = (e_reg + 1'b1 == scnt_reg);
                    if (e_reg + 1'b1 == scnt_reg)
                    begin
                        pcnt_next  = '0;
                        scnt_next  = '0;
                        state_next = C_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = C_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            pcnt_reg  <= '0;
            scnt_reg  <= '0;
            ov_reg    <= 1'b0;
            best_reg  <= '0;
            bidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pcnt_reg  <= pcnt_next;
            scnt_reg  <= scnt_next;
            ov_reg    <= ov_next;
            best_reg  <= best_next;
            bidx_reg  <= bidx_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        k_reg     <= k_next;
        e_reg     <= e_next;
        worst_reg <= worst_next;
        p_reg     <= p_next;
        sel_reg   <= sel_next;
        conj_reg  <= conj_next;
        rph_reg   <= rph_next;
        prod_reg  <= prod_next;
        od_reg    <= od_next;
        olast_reg <= olast_next;
        ostat_reg <= ostat_next;
    end

    // point memory
    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pcnt_reg[PIDX_W-1:0]] <= '{re: points.value_real, im: points.value_imag};
        pt_q_reg <= pt_mem[rd_addr];
    end

    // running product memory
    always_ff @(posedge clk)
    begin
        if (rp_we)
            rp_mem[k_reg[PIDX_W-1:0]] <= rp_wdata;
        rp_q_reg <= rp_mem[rd_addr];
    end

    // shift memory
    always_ff @(posedge clk)
    begin
        if (sh_we)
            sh_mem[scnt_reg[SIDX_W-1:0]] <= sh_wdata;
        sh_q_reg <= sh_mem[sh_raddr];
    end

    assign shifts.valid      = ov_reg;
    assign shifts.shift_real = od_reg.re;
    assign shifts.shift_imag = od_reg.im;
    assign shifts.shift_last = olast_reg;
    assign shifts.status     = ostat_reg;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        shifts.valid && shifts.status |-> shifts.shift_last)
        else $error("error result without last mark");
    a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= PCNT_W'(MAX_POINTS))
        else $error("point count out of range");
    a_scnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        scnt_reg <= SCNT_W'(MAX_SHIFTS))
        else $error("shift count out of range");
    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        rat_done |-> (state_reg == C_MM_WAIT || state_reg == C_AS_WAIT))
        else $error("ratio result arrived with no one waiting");
    a_load_no_shifts: assert property (@(posedge clk) disable iff (!rst_n)
        points.ready |-> scnt_reg == '0)
        else $error("shift count nonzero while loading");
`endif

endmodule

// ===== tb/tb_asms_channels.sv =====
`timescale 1ns / 1ps
// Testbench channel bundles: point transfer record and expected shift record.
package tb_asms_types;
    import asms_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     last;
    } point_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     last;
        logic                     status;
    } shift_item_t;
endpackage

// ===== tb/tb_adi_shift_minmax_select.sv =====
`timescale 1ns / 1ps
// Testbench top: drives point sets, predicts the selected ADI shifts and checks every shift transfer.
module tb_adi_shift_minmax_select;
    import asms_pkg::*;
    import tb_asms_types::*;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint SAT_RATIO   = 64'hFFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    asms_point_if pif ();
    asms_shift_if sif ();

    adi_shift_minmax_select uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (pif),
        .shifts  (sif),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pending points, expected shifts
    point_item_t point_pend_q[$];
    shift_item_t shift_expect_q[$];

    // predictor state
    longint      set_re[MAX_POINTS];
    longint      set_im[MAX_POINTS];
    int          set_count;
    longint      chosen_re[MAX_SHIFTS];
    longint      chosen_im[MAX_SHIFTS];
    int          chosen_count;
    longint unsigned gain_prod[MAX_POINTS];
    int          desired_cfg;

    int          fail_count;
    longint      cycle_count;
    int          gen_items;

    // sender / receiver pacing
    logic        point_took;
    int          send_gap;
    int          send_burst;
    int          stall_mode;
    int          stall_span;

    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // squared distance ratio |p-x|^2 / |p+x|^2 in Q16, saturating
    function automatic longint unsigned dist_ratio(longint pr, longint pi, longint xr, longint xi);
        longint unsigned a, b, c, d, num, den, q;
        a = magn(pr - xr);
        b = magn(pi - xi);
        c = magn(pr + xr);
        d = magn(pi + xi);
        while (a >= 64'h8000_0000 || b >= 64'h8000_0000 ||
               c >= 64'h8000_0000 || d >= 64'h8000_0000) begin
            a = a >> 1; b = b >> 1; c = c >> 1; d = d >> 1;
        end
        num = a * a + b * b;
        den = c * c + d * d;
        while (num >= (64'd1 << (64 - FRAC_BITS))) begin
            num = num >> 1;
            den = den >> 1;
        end
        if (den == 0)
            return SAT_RATIO;
        q = (num << FRAC_BITS) / den;
        return (q > SAT_RATIO) ? SAT_RATIO : q;
    endfunction

    function automatic longint unsigned prod_q(longint unsigned a, longint unsigned b);
        longint unsigned p;
        p = (a * b) >> FRAC_BITS;
        return (p > SAT_RATIO) ? SAT_RATIO : p;
    endfunction

    function automatic void append_shift(longint r, longint i);
        chosen_re[chosen_count] = r;
        chosen_im[chosen_count] = i;
        chosen_count++;
        for (int k = 0; k < set_count; k++)
            gain_prod[k] = prod_q(gain_prod[k], dist_ratio(r, i, set_re[k], set_im[k]));
    endfunction

    // adds a point plus its conjugate when complex; 0 when the shift list is full
    function automatic bit append_point(int idx);
        longint r, i;
        int need;
        r = set_re[idx];
        i = set_im[idx];
        need = (i != 0) ? 2 : 1;
        if (chosen_count + need > MAX_SHIFTS)
            return 0;
        append_shift(r, i);
        if (i != 0)
            append_shift(r, (i == -64'sh8000_0000) ? 64'sh7FFF_FFFF : -i);
        return 1;
    endfunction

    function automatic int greatest_gain();
        int best;
        best = 0;
        for (int k = 1; k < set_count; k++)
            if (gain_prod[k] > gain_prod[best])
                best = k;
        return best;
    endfunction

    // full selection on the loaded set; pushes the resulting shift list
    function automatic void select_shifts();
        shift_item_t e;
        longint unsigned worst, best_worst, q;
        int best;
        if (set_count < desired_cfg) begin
            e.re = '0; e.im = '0; e.last = 1'b1; e.status = 1'b1;
            shift_expect_q.push_back(e);
            set_count = 0;
            chosen_count = 0;
            return;
        end
        best = 0;
        best_worst = 0;
        for (int i = 0; i < set_count; i++) begin
            worst = 0;
            for (int k = 0; k < set_count; k++) begin
                q = dist_ratio(set_re[i], set_im[i], set_re[k], set_im[k]);
                if (q > worst)
                    worst = q;
            end
            if (i == 0 || worst < best_worst) begin
                best_worst = worst;
                best = i;
            end
        end
        chosen_count = 0;
        for (int k = 0; k < set_count; k++)
            gain_prod[k] = 64'd1 << FRAC_BITS;
        void'(append_point(best));
        best = greatest_gain();
        while (chosen_count < desired_cfg) begin
            if (!append_point(best))
                break;
            best = greatest_gain();
        end
        for (int k = 0; k < chosen_count; k++) begin
            e.re = chosen_re[k][31:0];
            e.im = chosen_im[k][31:0];
            e.last = (k + 1 == chosen_count);
            e.status = 1'b0;
            shift_expect_q.push_back(e);
        end
        set_count = 0;
        chosen_count = 0;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // known values on every input from time zero
    initial
    begin
        rst_n = 1'b0;
        pif.valid = 1'b0;
        pif.value_real = '0;
        pif.value_imag = '0;
        pif.last_point = 1'b0;
        sif.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // point sender: bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!pif.valid || point_took) begin
                if (send_gap > 0) begin
                    pif.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (point_pend_q.size() != 0) begin
                    point_item_t it;
                    it = point_pend_q.pop_front();
                    pif.valid <= 1'b1;
                    pif.value_real <= it.re;
                    pif.value_imag <= it.im;
                    pif.last_point <= it.last;
                    if (send_burst <= 1) begin
                        send_burst <= $urandom_range(1, 12);
                        send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        send_burst <= send_burst - 1;
                    end
                end else begin
                    pif.valid <= 1'b0;
                end
            end
        end
    end

    // shift receiver: always ready, mostly ready or mostly stalled, rechosen when its span runs out
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (stall_span == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_span <= $urandom_range(20, 200);
            end else begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                0: sif.ready <= 1'b1;
                1: sif.ready <= ($urandom_range(0, 3) != 0);
                default: sif.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // accepted points feed the predictor; accepted shifts are checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            point_took <= pif.valid && pif.ready;
            if (pif.valid && pif.ready) begin
                if (set_count < MAX_POINTS) begin
                    set_re[set_count] = longint'(pif.value_real);
                    set_im[set_count] = longint'(pif.value_imag);
                    set_count++;
                end
                if (pif.last_point)
                    select_shifts();
            end
            if (sif.valid && sif.ready) begin
                if (shift_expect_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected shift transfer re=%h im=%h last=%b status=%b",
                             $time, sif.shift_real, sif.shift_imag, sif.shift_last, sif.status);
                end else begin
                    shift_item_t e;
                    e = shift_expect_q.pop_front();
                    if (sif.shift_real !== e.re || sif.shift_imag !== e.im ||
                        sif.shift_last !== e.last || sif.status !== e.status) begin
                        fail_count++;
                        $display("%0t: shift mismatch expected re=%h im=%h last=%b status=%b",
                                 $time, e.re, e.im, e.last, e.status);
                        $display("%0t:                actual re=%h im=%h last=%b status=%b",
                                 $time, sif.shift_real, sif.shift_imag, sif.shift_last,
                                 sif.status);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] addr, input int value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_DESIRED)
            desired_cfg = value & 'h3F;
    endtask

    // block idle: nothing pending, nothing outstanding, then a short settle
    task automatic drain();
        while (point_pend_q.size() != 0 || pif.valid || shift_expect_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic push_point(input logic [31:0] re, input logic [31:0] im, input logic last);
        point_item_t it;
        it.re = re;
        it.im = im;
        it.last = last;
        point_pend_q.push_back(it);
        gen_items++;
    endtask

    function automatic logic [31:0] rand_real();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return -$urandom_range(1, 40 << FRAC_BITS);
        endcase
    endfunction

    function automatic logic [31:0] rand_imag();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2, 3: return 32'h0;
            default: return $urandom_range(1, 40 << FRAC_BITS);
        endcase
    endfunction

    // mostly conjugate-closed sets; now and then a lone complex point
    task automatic push_set(input int n);
        int left;
        logic [31:0] r, i;
        left = n;
        while (left > 0) begin
            r = rand_real();
            i = rand_imag();
            if (left >= 2 && i != 0 && $urandom_range(0, 5) != 0) begin
                push_point(r, i, 1'b0);
                push_point(r, -i, left == 2);
                left -= 2;
            end else begin
                push_point(r, (i != 0 && $urandom_range(0, 3) != 0) ? 32'h0 : i, left == 1);
                left -= 1;
            end
        end
    endtask

    // stimulus phases
    initial
    begin
        int nsets, sz;
        fail_count = 0;
        cycle_count = 0;
        gen_items = 0;
        set_count = 0;
        chosen_count = 0;
        desired_cfg = DESIRED_RESET;
        send_gap = 0;
        send_burst = 1;
        stall_mode = 0;
        stall_span = 0;
        point_took = 1'b0;
        wait (rst_n);
        @(posedge clk);

        // reset setting: too few points, then a real set
        push_point(-32'sd65536, 32'h0, 1'b0);
        push_point(-32'sd131072, 32'h0, 1'b0);
        push_point(-32'sd196608, 32'h0, 1'b1);
        push_set(9);
        drain();

        // zero desired: first shift only, real and complex
        cfg_write(ADDR_DESIRED, 0);
        push_point(-32'sd65536, 32'h0, 1'b1);
        push_point(-32'sd65536, 32'sd65536, 1'b0);
        push_point(-32'sd65536, -32'sd65536, 1'b1);
        drain();

        // one shift: field extremes, zero point, unstable point, imag -2^31 conjugate
        cfg_write(ADDR_DESIRED, 1);
        push_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        push_point(32'h0, 32'h0, 1'b1);
        push_point(32'sd65536, 32'h0, 1'b0);
        push_point(-32'sd65536, 32'h0, 1'b1);
        push_point(-32'sd65536, 32'h8000_0000, 1'b1);
        drain();

        // maximum desired: shift list runs full on conjugate pairs
        cfg_write(ADDR_DESIRED, 63);
        for (int k = 0; k < 32; k++) begin
            push_point(-$urandom_range(1, 40 << FRAC_BITS), $urandom_range(1, 1 << 22), 1'b0);
            push_point(point_pend_q[$].re, -point_pend_q[$].im, k == 31);
        end
        // too few for 63
        push_set(5);
        drain();

        // point store overflow: extra points dropped
        cfg_write(ADDR_DESIRED, 3);
        for (int k = 0; k < 66; k++)
            push_point(-$urandom_range(1, 40 << FRAC_BITS), 32'h0, k == 65);
        drain();

        // random phases, mostly small sets
        while (gen_items < 180) begin
            case ($urandom_range(0, 9))
                0: cfg_write(ADDR_DESIRED, 63);
                1: cfg_write(ADDR_DESIRED, 0);
                default: cfg_write(ADDR_DESIRED, $urandom_range(1, 6));
            endcase
            nsets = $urandom_range(1, 3);
            for (int s = 0; s < nsets; s++) begin
                sz = $urandom_range(1, 10);
                push_set(sz);
            end
            drain();
        end

        cfg_write(ADDR_DESIRED, DESIRED_RESET);
        push_set(8);
        drain();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
